// File: design/tiny_rc4_stream_cipher_assert.svh
// Assertion macros used by the tiny RC4 stream cipher RTL.
// Expects clk_i and rst_ni to be in scope where a macro is used.
`ifndef TINY_RC4_STREAM_CIPHER_ASSERT_SVH
`define TINY_RC4_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define TRC4_ASSERT_IMPLIES(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("trc4 assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define TRC4_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("trc4 assertion failed");

`endif

// File: design/trc4_pkg.sv
// Shared types and constants of the tiny RC4 stream cipher.
// No dependencies; every other design file but the assertion macro header imports it.
`default_nettype none

package trc4_pkg;

  localparam int unsigned TableEntries = 8;
  localparam int unsigned SymW         = 3;
  localparam int unsigned KeyLenW      = 4;
  localparam int unsigned KeyWords     = 8;
  localparam int unsigned KeyWordsW    = KeyWords * SymW;
  localparam int unsigned AddrW        = 3;
  localparam int unsigned DataW        = 32;

  typedef logic [SymW-1:0]      sym_t;
  typedef logic [KeyLenW-1:0]   key_len_t;
  typedef logic [KeyWordsW-1:0] key_words_t;
  typedef logic [AddrW-1:0]     apb_addr_t;
  typedef logic [DataW-1:0]     apb_data_t;

  // Datapath operations, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_FILL,
    OP_KS_RD_I,
    OP_KS_RD_J,
    OP_KS_WR_I,
    OP_KS_WR_J,
    OP_GEN_RD_I,
    OP_GEN_RD_J,
    OP_GEN_SWAP,
    OP_GEN_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_sym;
  } dp_cmd_t;

  typedef struct packed {
    logic keyed;
    logic n_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: design/trc4_stream_if.sv
// Stream channel interfaces of the tiny RC4 stream cipher: plaintext in, ciphertext out.
// Depends on trc4_pkg for the symbol type.
`default_nettype none

interface trc4_in_if;
  import trc4_pkg::*;
  logic valid;
  logic ready;
  sym_t symbol;
  logic new_message;

  modport source (output valid, output symbol, output new_message, input ready);
  modport sink (input valid, input symbol, input new_message, output ready);
endinterface

interface trc4_out_if;
  import trc4_pkg::*;
  logic valid;
  logic ready;
  sym_t cipher_symbol;

  modport source (output valid, output cipher_symbol, input ready);
  modport sink (input valid, input cipher_symbol, output ready);
endinterface

`default_nettype wire

// File: design/trc4_regs.sv
// APB configuration registers of the tiny RC4 stream cipher: key length and key words.
// Depends on trc4_pkg.
`default_nettype none

module trc4_regs (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  trc4_pkg::apb_addr_t   paddr,
  input  trc4_pkg::apb_data_t   pwdata,
  output trc4_pkg::apb_data_t   prdata,
  output logic                  pready,
  output trc4_pkg::key_len_t    key_length_o,
  output trc4_pkg::key_words_t  key_words_o
);
  import trc4_pkg::*;

  localparam logic RegKeyLength = 1'b0;
  localparam logic RegKeyWords  = 1'b1;

  key_len_t   key_length_q;
  key_words_t key_words_q;
  logic       wr_en;
  logic       reg_sel;

  // Registers sit on 4-byte boundaries; bit 2 picks one
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Take a write on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= key_len_t'(1);
      key_words_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegKeyLength: key_length_q <= pwdata[KeyLenW-1:0];
        RegKeyWords:  key_words_q  <= pwdata[KeyWordsW-1:0];
        default:      ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      RegKeyLength: prdata = {{(DataW-KeyLenW){1'b0}}, key_length_q};
      RegKeyWords:  prdata = {{(DataW-KeyWordsW){1'b0}}, key_words_q};
      default:      prdata = '0;
    endcase
  end

  assign key_length_o = key_length_q;
  assign key_words_o  = key_words_q;

endmodule

`default_nettype wire

// File: design/trc4_dp.sv
// Datapath of the tiny RC4 stream cipher: permutation memory, counters, output register.
// Depends on trc4_pkg; driven by trc4_ctrl through dp_cmd_t.
`default_nettype none

module trc4_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  trc4_pkg::dp_cmd_t     cmd_i,
  output trc4_pkg::dp_status_t  status_o,
  input  trc4_pkg::sym_t        symbol_i,
  input  trc4_pkg::key_len_t    key_length_i,
  input  trc4_pkg::key_words_t  key_words_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output trc4_pkg::sym_t        cipher_symbol_o
);
  import trc4_pkg::*;

  // Permutation memory: one write port, two registered read ports
  sym_t perm_q [TableEntries];
  sym_t rd_a_q, rd_b_q;
  sym_t raddr_a, raddr_b;
  logic we;
  sym_t waddr, wdata;

  sym_t n_q, n_d;
  sym_t kp_q, kp_d;
  sym_t i_q, i_d;
  sym_t j_q, j_d;
  sym_t si_q, si_d;
  sym_t sj_q, sj_d;
  sym_t t_q, t_d;
  sym_t sym_q;
  logic keyed_q, keyed_d;
  logic out_valid_q, out_valid_d;
  sym_t out_data_q, out_data_d;

  logic [KeyWords-1:0][SymW-1:0] key_arr;
  key_len_t len_eff;
  key_len_t kp_inc;
  sym_t     kw;
  logic     out_free;

  function automatic sym_t symbol_xor(sym_t a, sym_t b);
    return a ^ b;
  endfunction

  assign key_arr = key_words_i;
  assign kw      = key_arr[kp_q];

  // Clamp the key length to 1..8
  always_comb begin
    priority if (key_length_i == '0) begin
      len_eff = key_len_t'(1);
    end else if (key_length_i > key_len_t'(KeyWords)) begin
      len_eff = key_len_t'(KeyWords);
    end else begin
      len_eff = key_length_i;
    end
  end

  assign kp_inc   = {1'b0, kp_q} + key_len_t'(1);
  assign out_free = !out_valid_q || out_ready_i;

  // Decode the operation into memory accesses and next register values
  always_comb begin
    sym_t nj;
    sym_t ni;
    sym_t ks;
    nj          = '0;
    ni          = '0;
    ks          = '0;
    we          = 1'b0;
    waddr       = n_q;
    wdata       = n_q;
    raddr_a     = n_q;
    raddr_b     = j_q;
    n_d         = n_q;
    kp_d        = kp_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    keyed_d     = keyed_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (cmd_i.op)
      OP_NONE: ;
      OP_FILL: begin
        we    = 1'b1;
        waddr = n_q;
        wdata = n_q;
        n_d   = n_q + sym_t'(1);
        kp_d  = '0;
        i_d   = '0;
        j_d   = '0;
      end
      OP_KS_RD_I: begin
        raddr_a = n_q;
      end
      OP_KS_RD_J: begin
        nj      = j_q + rd_a_q + kw;
        j_d     = nj;
        si_d    = rd_a_q;
        raddr_b = nj;
      end
      OP_KS_WR_I: begin
        we    = 1'b1;
        waddr = n_q;
        wdata = rd_b_q;
      end
      OP_KS_WR_J: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        n_d   = n_q + sym_t'(1);
        kp_d  = (kp_inc == len_eff) ? '0 : kp_inc[SymW-1:0];
        if (n_q == sym_t'(TableEntries - 1)) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      OP_GEN_RD_I: begin
        ni      = i_q + sym_t'(1);
        i_d     = ni;
        raddr_a = ni;
      end
      OP_GEN_RD_J: begin
        nj      = j_q + rd_a_q;
        j_d     = nj;
        si_d    = rd_a_q;
        raddr_b = nj;
      end
      OP_GEN_SWAP: begin
        we      = 1'b1;
        waddr   = i_q;
        wdata   = rd_b_q;
        sj_d    = rd_b_q;
        t_d     = si_q + rd_b_q;
        raddr_a = si_q + rd_b_q;
      end
      OP_GEN_OUT: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        // The read of S[t] predates the swap; patch it for the swapped entries
        priority if (t_q == i_q) begin
          ks = sj_q;
        end else if (t_q == j_q) begin
          ks = si_q;
        end else begin
          ks = rd_a_q;
        end
        out_data_d  = symbol_xor(sym_q, ks);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // Memory write and registered reads; hold the read data while no operation runs
  always_ff @(posedge clk_i) begin
    if (we) begin
      perm_q[waddr] <= wdata;
    end
    if (cmd_i.op != OP_NONE) begin
      rd_a_q <= perm_q[raddr_a];
      rd_b_q <= perm_q[raddr_b];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      kp_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      kp_q        <= kp_d;
      i_q         <= i_d;
      j_q         <= j_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    out_data_q <= out_data_d;
    if (cmd_i.load_sym) begin
      sym_q <= symbol_i;
    end
  end

  assign status_o.keyed    = keyed_q;
  assign status_o.n_last   = (n_q == sym_t'(TableEntries - 1));
  assign status_o.out_free = out_free;

  assign out_valid_o     = out_valid_q;
  assign cipher_symbol_o = out_data_q;

endmodule

`default_nettype wire

// File: design/trc4_ctrl.sv
// Controller of the tiny RC4 stream cipher: sequences key schedule and generator steps.
// Depends on trc4_pkg and the assertion macro header.
`default_nettype none
`include "tiny_rc4_stream_cipher_assert.svh"

module trc4_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   new_message_i,
  output logic                  in_ready_o,
  input  trc4_pkg::dp_status_t  status_i,
  output trc4_pkg::dp_cmd_t     cmd_o
);
  import trc4_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_WR_I,
    ST_KS_WR_J,
    ST_GEN_RD_I,
    ST_GEN_RD_J,
    ST_GEN_SWAP,
    ST_GEN_OUT
  } state_e;

  state_e state_q;
  logic   accept;
  logic   need_sched;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign need_sched = new_message_i || !status_i.keyed;

  // Issue the datapath operation for the current step
  always_comb begin
    cmd_o.load_sym = accept;
    unique case (state_q)
      ST_IDLE: begin
        priority if (!accept) begin
          cmd_o.op = OP_NONE;
        end else if (need_sched) begin
          cmd_o.op = OP_FILL;
        end else begin
          cmd_o.op = OP_GEN_RD_I;
        end
      end
      ST_FILL:     cmd_o.op = OP_FILL;
      ST_KS_RD_I:  cmd_o.op = OP_KS_RD_I;
      ST_KS_RD_J:  cmd_o.op = OP_KS_RD_J;
      ST_KS_WR_I:  cmd_o.op = OP_KS_WR_I;
      ST_KS_WR_J:  cmd_o.op = OP_KS_WR_J;
      ST_GEN_RD_I: cmd_o.op = OP_GEN_RD_I;
      ST_GEN_RD_J: cmd_o.op = OP_GEN_RD_J;
      ST_GEN_SWAP: cmd_o.op = OP_GEN_SWAP;
      ST_GEN_OUT:  cmd_o.op = status_i.out_free ? OP_GEN_OUT : OP_NONE;
      default:     cmd_o.op = OP_NONE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= need_sched ? ST_FILL : ST_GEN_RD_J;
          end
        end
        ST_FILL: begin
          if (status_i.n_last) begin
            state_q <= ST_KS_RD_I;
          end
        end
        ST_KS_RD_I: state_q <= ST_KS_RD_J;
        ST_KS_RD_J: state_q <= ST_KS_WR_I;
        ST_KS_WR_I: state_q <= ST_KS_WR_J;
        ST_KS_WR_J: begin
          state_q <= status_i.n_last ? ST_GEN_RD_I : ST_KS_RD_I;
        end
        ST_GEN_RD_I: state_q <= ST_GEN_RD_J;
        ST_GEN_RD_J: state_q <= ST_GEN_SWAP;
        ST_GEN_SWAP: state_q <= ST_GEN_OUT;
        ST_GEN_OUT: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `TRC4_ASSERT_NEXT(a_accept_busy, accept, !in_ready_o)
  `TRC4_ASSERT_IMPLIES(a_gen_keyed, state_q == ST_GEN_RD_J, status_i.keyed)
  `TRC4_ASSERT_IMPLIES(a_out_free, cmd_o.op == OP_GEN_OUT, status_i.out_free)

endmodule

`default_nettype wire

// File: design/tiny_rc4_stream_cipher.sv
// Tiny RC4 stream cipher top level: APB registers, controller and datapath.
// Depends on trc4_pkg, trc4_stream_if, trc4_regs, trc4_ctrl and trc4_dp.
//
// Usage:
//   Write key_length (byte 0) and key_words (byte 4) over APB while the block is idle.
//   Each transaction on plain_i carries one 3-bit symbol and a new_message flag;
//   each produces one transaction on cipher_o carrying symbol XOR keystream.
//   The result passes the generator steps read S[i], read S[j], swap and output into
//   the output register; the next symbol is accepted only once the controller is back
//   in idle with that result registered, set by the dependent reads and two-write swap
//   on the single write port of the 8-entry permutation memory.
//   The first symbol after reset, and any symbol with new_message set, first runs
//   the key schedule: identity fill of the permutation memory, then 8 swap steps of
//   read S[n], read S[j], write S[n] and write S[j], then clears both counters.
//   Reset empties the output register and marks the key schedule as not yet run.
//   When the receiver stalls, the result waits in the output register; one more
//   symbol is accepted and processed, and it holds at its last step until the
//   output register frees.
`default_nettype none

module tiny_rc4_stream_cipher (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  trc4_in_if.sink              plain_i,
  trc4_out_if.source           cipher_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  trc4_pkg::apb_addr_t  paddr,
  input  trc4_pkg::apb_data_t  pwdata,
  output trc4_pkg::apb_data_t  prdata,
  output logic                 pready
);
  import trc4_pkg::*;

  key_len_t   key_length;
  key_words_t key_words;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;
  sym_t       out_symbol;

  // Configuration registers
  trc4_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .key_length_o (key_length),
    .key_words_o  (key_words)
  );

  // Sequencer
  trc4_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (plain_i.valid),
    .new_message_i (plain_i.new_message),
    .in_ready_o    (in_ready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // Permutation memory and generator
  trc4_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .symbol_i        (plain_i.symbol),
    .key_length_i    (key_length),
    .key_words_i     (key_words),
    .out_valid_o     (out_valid),
    .out_ready_i     (cipher_o.ready),
    .cipher_symbol_o (out_symbol)
  );

  assign plain_i.ready          = in_ready;
  assign cipher_o.valid         = out_valid;
  assign cipher_o.cipher_symbol = out_symbol;

endmodule

`default_nettype wire
